FILE: hdl/dedf_pkg.sv
package dedf_pkg;

    // widths of the event length and run counters
    localparam int LEN_W = 28;
    localparam int RUN_W = 20;

    // header layout
    localparam logic [3:0]       HDR_MAGIC    = 4'hA;
    localparam logic [LEN_W-1:0] HEADER_WORDS = 28'd4;
    localparam logic [LEN_W-1:0] LEN_MAX      = 28'hFFF_FFFF;

    // result kinds
    localparam logic [1:0] KIND_PAIR = 2'd0;
    localparam logic [1:0] KIND_GAP  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // gap filler sample value
    localparam logic [15:0] GAP_SAMPLE = 16'hFFFF;

    // packed output data width: channel, two samples, repeat count, padded to bytes
    localparam int ODATA_W = 56;

    // controller to datapath
    typedef struct packed {
        logic step;       // one input transaction is taken this cycle
        logic div_start;  // launch the per-channel word count division
    } t_dedf_cmd;

    // datapath to controller
    typedef struct packed {
        logic mask_word;  // the word on the input is the mode and mask header word
        logic div_done;   // division result ready this cycle
        logic out_valid;  // output register holds a result
    } t_dedf_sts;

    // index of the lowest set bit, 0 when none
    function automatic logic [2:0] lowest_set(input logic [7:0] m);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                r = i[2:0];
            end
        end
        return r;
    endfunction

    // number of set bits
    function automatic logic [3:0] count_set(input logic [7:0] m);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(m[i]);
        end
        return n;
    endfunction

endpackage

FILE: hdl/dedf_div.sv
module dedf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dedf_pkg::LEN_W-1:0]  i_dividend,
    input  logic [3:0]                  i_divisor,
    output logic                        o_done,
    output logic [dedf_pkg::LEN_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(dedf_pkg::LEN_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [dedf_pkg::LEN_W-1:0] r_dvd;
    logic [dedf_pkg::LEN_W-1:0] r_quo;
    logic [2:0]                 r_rem;
    logic [3:0]                 r_dsr;

    logic [3:0] trial;
    logic       fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {r_rem, r_dvd[dedf_pkg::LEN_W-1]};
    assign fits  = (trial >= r_dsr);

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(dedf_pkg::LEN_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // operand and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= 3'd0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[dedf_pkg::LEN_W-2:0], 1'b0};
            r_quo <= {r_quo[dedf_pkg::LEN_W-2:0], fits};
            r_rem <= fits ? 3'(trial - r_dsr) : trial[2:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hdl/dedf_dp.sv
module dedf_dp #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dedf_pkg::t_dedf_cmd         i_cmd,
    output dedf_pkg::t_dedf_sts         o_sts,
    input  logic [31:0]                 i_word,
    input  logic                        i_event_start,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_kind,
    output logic [2:0]                  o_channel,
    output logic [15:0]                 o_sample_first,
    output logic [15:0]                 o_sample_second,
    output logic [dedf_pkg::RUN_W-1:0]  o_repeat_res
);

    localparam int LW = dedf_pkg::LEN_W;
    localparam int RW = dedf_pkg::RUN_W;
    localparam logic [15:0] SMASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    // event state
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_len, n_len;
    logic          r_mode, n_mode;
    logic [7:0]    r_en, n_en;
    logic [2:0]    r_ch, n_ch;
    logic [LW-1:0] r_wl, n_wl;
    logic [LW-1:0] r_wpc, n_wpc;
    logic          r_ectl, n_ectl;
    logic          r_good, n_good;
    logic [RW-1:0] r_rlen, n_rlen;
    logic [RW-1:0] r_rdone, n_rdone;
    logic          r_disc, n_disc;
    logic          r_div_ok, n_div_ok;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [2:0]    r_out_ch;
    logic [15:0]   r_out_a;
    logic [15:0]   r_out_b;
    logic [RW-1:0] r_out_rep;

    // step results
    logic          res_v;
    logic [1:0]    res_kind;
    logic [2:0]    res_ch;
    logic [15:0]   res_a;
    logic [15:0]   res_b;
    logic [RW-1:0] res_rep;

    logic [7:0]    mask;
    logic [3:0]    nch;
    logic [LW-1:0] wl_dec;
    logic [31:0]   w_m1;
    logic [LW-1:0] sz_cnt;
    logic          fin;
    logic [7:0]    en_left;
    logic [RW-1:0] rd_inc;
    logic [LW-1:0] wpc_q;
    logic          div_done;
    logic [LW-1:0] quotient;

    // channel mask and count from the mode word
    assign mask   = 8'(i_word[NUM_CHANNELS-1:0]);
    assign nch    = dedf_pkg::count_set(mask);
    assign wl_dec = r_wl - LW'(1);
    assign w_m1   = i_word - 32'd1;

    // channel size word: words after the size word, saturated
    always_comb begin
        if (i_word == 32'd0) begin
            sz_cnt = '0;
        end else if (w_m1[31:LW] != '0) begin
            sz_cnt = dedf_pkg::LEN_MAX;
        end else begin
            sz_cnt = w_m1[LW-1:0];
        end
    end

    // next state for one word, or for the division result
    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_mode   = r_mode;
        n_en     = r_en;
        n_ch     = r_ch;
        n_wl     = r_wl;
        n_wpc    = r_wpc;
        n_ectl   = r_ectl;
        n_good   = r_good;
        n_rlen   = r_rlen;
        n_rdone  = r_rdone;
        n_disc   = r_disc;
        n_div_ok = r_div_ok;
        res_v    = 1'b0;
        res_kind = dedf_pkg::KIND_PAIR;
        res_ch   = r_ch;
        res_a    = i_word[15:0] & SMASK;
        res_b    = i_word[31:16] & SMASK;
        res_rep  = RW'(1);
        fin      = 1'b0;
        en_left  = r_en & ~(8'd1 << r_ch);
        rd_inc   = r_good ? (r_rdone + RW'(1)) : r_rdone;
        wpc_q    = r_div_ok ? quotient : '0;
        if (i_cmd.step) begin
            if (i_event_start) begin
                n_mode  = 1'b0;
                n_en    = '0;
                n_ch    = '0;
                n_wl    = '0;
                n_wpc   = '0;
                n_ectl  = 1'b1;
                n_good  = 1'b0;
                n_rlen  = '0;
                n_rdone = '0;
                if (i_word[31:28] != dedf_pkg::HDR_MAGIC) begin
                    n_disc   = 1'b1;
                    n_pos    = '0;
                    n_len    = '0;
                    res_v    = 1'b1;
                    res_kind = dedf_pkg::KIND_ERR;
                    res_ch   = '0;
                    res_a    = '0;
                    res_b    = '0;
                    res_rep  = '0;
                end else begin
                    n_disc = 1'b0;
                    n_len  = i_word[LW-1:0];
                    n_pos  = (i_word[LW-1:0] > LW'(1)) ? LW'(1) : '0;
                end
            end else if (!r_disc && r_pos != '0) begin
                if (r_pos == LW'(1)) begin
                    // mode and mask word
                    n_mode   = i_word[24];
                    n_en     = mask;
                    n_ch     = dedf_pkg::lowest_set(mask);
                    n_div_ok = (nch != 4'd0) && (r_len > dedf_pkg::HEADER_WORDS);
                    if (i_word[24]) begin
                        n_wl = '0;
                    end
                end else if (r_pos >= dedf_pkg::HEADER_WORDS && r_en != 8'd0) begin
                    if (!r_mode) begin
                        // plain payload
                        res_v = 1'b1;
                        if (wl_dec == '0) begin
                            fin = 1'b1;
                        end else begin
                            n_wl = wl_dec;
                        end
                    end else if (r_wl == '0) begin
                        // channel size word
                        if (sz_cnt == '0) begin
                            fin = 1'b1;
                        end else begin
                            n_wl = sz_cnt;
                        end
                    end else begin
                        n_wl = wl_dec;
                        if (r_ectl) begin
                            // control word
                            n_good  = i_word[31];
                            n_rlen  = i_word[RW-1:0];
                            n_rdone = '0;
                            if (i_word[31]) begin
                                n_ectl = 1'b0;
                            end else if (i_word[RW-1:0] != '0) begin
                                res_v    = 1'b1;
                                res_kind = dedf_pkg::KIND_GAP;
                                res_a    = dedf_pkg::GAP_SAMPLE;
                                res_b    = dedf_pkg::GAP_SAMPLE;
                                res_rep  = i_word[RW-1:0];
                            end
                        end else begin
                            // data word of a run
                            res_v   = r_good;
                            n_rdone = rd_inc;
                            if (rd_inc == r_rlen) begin
                                n_ectl = 1'b1;
                            end
                        end
                        if (wl_dec == '0) begin
                            fin = 1'b1;
                        end
                    end
                    // move on to the next enabled channel
                    if (fin) begin
                        n_en = en_left;
                        if (en_left != 8'd0) begin
                            n_ch = dedf_pkg::lowest_set(en_left);
                        end
                        n_wl = r_mode ? '0 : r_wpc;
                    end
                end
                n_pos = (({1'b0, r_pos} + (LW+1)'(1)) >= {1'b0, r_len}) ? '0
                                                                         : r_pos + LW'(1);
            end
        end else if (div_done) begin
            n_wpc = wpc_q;
            if (!r_mode) begin
                n_wl = wpc_q;
                if (wpc_q == '0) begin
                    n_en = '0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_mode   <= 1'b0;
            r_en     <= '0;
            r_ch     <= '0;
            r_wl     <= '0;
            r_wpc    <= '0;
            r_ectl   <= 1'b1;
            r_good   <= 1'b0;
            r_rlen   <= '0;
            r_rdone  <= '0;
            r_disc   <= 1'b0;
            r_div_ok <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_mode   <= n_mode;
            r_en     <= n_en;
            r_ch     <= n_ch;
            r_wl     <= n_wl;
            r_wpc    <= n_wpc;
            r_ectl   <= n_ectl;
            r_good   <= n_good;
            r_rlen   <= n_rlen;
            r_rdone  <= n_rdone;
            r_disc   <= n_disc;
            r_div_ok <= n_div_ok;
        end
    end

    // words per channel divider
    dedf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_len - dedf_pkg::HEADER_WORDS),
        .i_divisor  (nch),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && res_v) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && res_v) begin
            r_out_kind <= res_kind;
            r_out_ch   <= res_ch;
            r_out_a    <= res_a;
            r_out_b    <= res_b;
            r_out_rep  <= res_rep;
        end
    end

    assign o_sts.mask_word = !i_event_start && !r_disc && (r_pos == LW'(1));
    assign o_sts.div_done  = div_done;
    assign o_sts.out_valid = r_out_valid;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_channel       = r_out_ch;
    assign o_sample_first  = r_out_a;
    assign o_sample_second = r_out_b;
    assign o_repeat_res    = r_out_rep;

    // an error result carries no channel and no repeat count
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == dedf_pkg::KIND_ERR) |-> (r_out_rep == '0 && r_out_ch == '0))
        else $error("error result with channel or repeat set");

endmodule

FILE: hdl/dedf_ctrl.sv
module dedf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_m_tready,
    input  dedf_pkg::t_dedf_sts  i_sts,
    output logic                 o_s_tready,
    output dedf_pkg::t_dedf_cmd  o_cmd
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic r_state, n_state;

    // take a word when not dividing and the output register can take a result
    assign o_s_tready      = (r_state == ST_RUN) && (!i_sts.out_valid || i_m_tready);
    assign o_cmd.step      = i_s_tvalid && o_s_tready;
    assign o_cmd.div_start = o_cmd.step && i_sts.mask_word;

    // state transitions
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (o_cmd.div_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == ST_DIV))
        else $error("division launched without waiting for it");

    a_no_step_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_cmd.step)
        else $error("word taken while division runs");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV))
        else $error("division result outside the division wait");

endmodule

FILE: hdl/digitizer_event_deframer_core.sv
// channel   | dir | tdata                                          | tuser
// ----------+-----+------------------------------------------------+------------------
// s_axis    | in  | [31:0] word                                    | [0] event_start
// m_axis    | out | [2:0] channel, [18:3] sample_first,            | [1:0] kind
//           |     | [34:19] sample_second, [54:35] repeat_res      |
//
// one input word per cycle while not dividing; after the mode and mask header
// word, s_axis is held while the serial divider forms the per-channel word
// count one bit a cycle, until its result is handed over to the datapath.
// at most one result per word, held in an output register; a stalled
// m_axis holds s_axis only when the register is full and not being taken.
// synchronous active-low reset clears all event and handshake state.
module digitizer_event_deframer_core #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // word
    input  logic                          s_axis_tuser,   // event_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dedf_pkg::ODATA_W-1:0]  m_axis_tdata,   // channel, sample_first,
                                                          // sample_second, repeat_res
    output logic [1:0]                    m_axis_tuser    // kind
);

    dedf_pkg::t_dedf_cmd cmd;
    dedf_pkg::t_dedf_sts sts;

    logic [2:0]                 channel;
    logic [15:0]                sample_first;
    logic [15:0]                sample_second;
    logic [dedf_pkg::RUN_W-1:0] repeat_res;

    // handshake and sequencing
    dedf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // event decoding and result register
    dedf_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_word          (s_axis_tdata),
        .i_event_start   (s_axis_tuser),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_kind          (m_axis_tuser),
        .o_channel       (channel),
        .o_sample_first  (sample_first),
        .o_sample_second (sample_second),
        .o_repeat_res    (repeat_res)
    );

    // pack result fields, lowest field first, zero padded
    assign m_axis_tdata = {1'b0, repeat_res, sample_second, sample_first, channel};

endmodule
